[sv/multicycle_cpu_datapath_assert.svh]
// Assertion macros shared by the datapath RTL.
`ifndef MULTICYCLE_CPU_DATAPATH_ASSERT_SVH
`define MULTICYCLE_CPU_DATAPATH_ASSERT_SVH

// Same-cycle implication, checked on i_clk and disabled in reset.
`define MCD_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("mcd: same-cycle check failed");

// Next-cycle implication, checked on i_clk and disabled in reset.
`define MCD_ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("mcd: next-cycle check failed");

`endif

[sv/mcd_pkg.sv]
// Types and constants of the multicycle datapath.
package mcd_pkg;

    localparam int WORD_BITS = 16;
    localparam int REG_COUNT = 16;
    localparam int REG_AW    = $clog2(REG_COUNT);

    // Register written when the destination select picks the fixed link register
    localparam logic [REG_AW-1:0] LINK_REG = REG_AW'(15);

    // Mode codes
    localparam logic [1:0] MODE_RUN   = 2'd0;
    localparam logic [1:0] MODE_CLEAR = 2'd1;
    localparam logic [1:0] MODE_HOLD  = 2'd2;

    // Load enable bit positions
    localparam int EN_INSTR  = 0;
    localparam int EN_A      = 1;
    localparam int EN_B      = 2;
    localparam int EN_PC     = 3;
    localparam int EN_RESULT = 4;
    localparam int EN_MDR    = 5;

    // ALU operation codes
    localparam logic [3:0] ALU_ADD   = 4'd0;
    localparam logic [3:0] ALU_SUB   = 4'd1;
    localparam logic [3:0] ALU_AND   = 4'd2;
    localparam logic [3:0] ALU_OR    = 4'd3;
    localparam logic [3:0] ALU_NOTA  = 4'd4;
    localparam logic [3:0] ALU_SHL   = 4'd5;
    localparam logic [3:0] ALU_SHR   = 4'd6;
    localparam logic [3:0] ALU_IMM8  = 4'd7;
    localparam logic [3:0] ALU_BIMLO = 4'd8;
    localparam logic [3:0] ALU_BIMHI = 4'd9;
    localparam logic [3:0] ALU_PCINC = 4'd10;
    localparam logic [3:0] ALU_PCREL = 4'd11;
    localparam logic [3:0] ALU_JUMP  = 4'd12;
    localparam logic [3:0] ALU_PASSA = 4'd13;

    typedef logic [WORD_BITS-1:0] t_word;

    // One control word plus memory data
    typedef struct packed {
        logic [1:0] mode;
        logic [3:0] alu_op;
        t_word      data_in;
        logic [5:0] enables;
        logic       dest_sel;
        logic       din_sel;
        logic       rf_we;
        logic       addr_sel;
    } t_in_item;

    // Datapath outputs for one control word
    typedef struct packed {
        logic [3:0] opcode;
        t_word      st_data;
        t_word      mem_addr;
        logic       zero_flag;
        logic       neg_flag;
    } t_out_item;

    // Operands handed to the ALU
    typedef struct packed {
        logic [3:0] op;
        t_word      a;
        t_word      b;
        t_word      pc;
        t_word      ir;
    } t_alu_in;

endpackage

[sv/mcd_if.sv]
// Valid/ready channels carrying control words in and datapath outputs out.
interface mcd_in_if;
    logic              valid;
    logic              ready;
    mcd_pkg::t_in_item payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

interface mcd_out_if;
    logic               valid;
    logic               ready;
    mcd_pkg::t_out_item payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

[sv/mcd_ram.sv]
// Generic RAM: one write port, two registered read ports with read enables.
module mcd_ram #(
    parameter int DATA_W = 16,
    parameter int DEPTH  = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [DATA_W-1:0]        i_wdata,
    input  logic                     i_re_a,
    input  logic [$clog2(DEPTH)-1:0] i_raddr_a,
    output logic [DATA_W-1:0]        o_rdata_a,
    input  logic                     i_re_b,
    input  logic [$clog2(DEPTH)-1:0] i_raddr_b,
    output logic [DATA_W-1:0]        o_rdata_b
);

    logic [DATA_W-1:0] r_mem [DEPTH];
    logic [DATA_W-1:0] r_rdata_a;
    logic [DATA_W-1:0] r_rdata_b;

    // Write port; reads see the old contents on an address collision
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re_a) begin
            r_rdata_a <= r_mem[i_raddr_a];
        end
        if (i_re_b) begin
            r_rdata_b <= r_mem[i_raddr_b];
        end
    end

    assign o_rdata_a = r_rdata_a;
    assign o_rdata_b = r_rdata_b;

endmodule

[sv/mcd_alu.sv]
// Fourteen-operation 16-bit ALU.
module mcd_alu (
    input  mcd_pkg::t_alu_in i_alu,
    output mcd_pkg::t_word   o_res
);

    mcd_pkg::t_word w_disp;

    // Sign-extended branch displacement from instr[11:4]
    assign w_disp = {{8{i_alu.ir[11]}}, i_alu.ir[11:4]};

    always_comb begin
        case (i_alu.op)
            mcd_pkg::ALU_ADD:   o_res = i_alu.a + i_alu.b;
            mcd_pkg::ALU_SUB:   o_res = i_alu.a - i_alu.b;
            mcd_pkg::ALU_AND:   o_res = i_alu.a & i_alu.b;
            mcd_pkg::ALU_OR:    o_res = i_alu.a | i_alu.b;
            mcd_pkg::ALU_NOTA:  o_res = ~i_alu.a;
            mcd_pkg::ALU_SHL:   o_res = i_alu.a << i_alu.b[3:0];
            mcd_pkg::ALU_SHR:   o_res = i_alu.a >> i_alu.b[3:0];
            mcd_pkg::ALU_IMM8:  o_res = {8'h00, i_alu.ir[7:0]};
            mcd_pkg::ALU_BIMLO: o_res = i_alu.b + {12'h000, i_alu.ir[7:4]};
            mcd_pkg::ALU_BIMHI: o_res = i_alu.b + {12'h000, i_alu.ir[11:8]};
            mcd_pkg::ALU_PCINC: o_res = i_alu.pc + 16'd1;
            mcd_pkg::ALU_PCREL: o_res = i_alu.pc + w_disp;
            mcd_pkg::ALU_JUMP:  o_res = {i_alu.pc[15:12], i_alu.ir[11:0]};
            mcd_pkg::ALU_PASSA: o_res = i_alu.a;
            default:            o_res = '0;
        endcase
    end

endmodule

[sv/multicycle_cpu_datapath.sv]
// Multicycle CPU datapath top level: input register, datapath state, output register.
// An accepted control word passes through the input register, then the state/out register, which raises output valid.
// Throughput: one control word per cycle while outputs are taken; a stalled output
// backs up into the input register, then input ready drops.
// Register file reads are registered RAM reads, resolved in the following control word.
// Reset (sync, active low) zeroes the datapath state, register valid bits and outputs, with zero_flag set to 1.
`include "multicycle_cpu_datapath_assert.svh"

module multicycle_cpu_datapath (
    input logic      i_clk,
    input logic      i_rst_n,
    mcd_in_if.sink   i_ctrl,
    mcd_out_if.source o_res
);

    localparam int AW = mcd_pkg::REG_AW;

    // Input register
    logic              r_in_valid;
    mcd_pkg::t_in_item r_in;

    // Architectural state
    mcd_pkg::t_word r_pc, r_instr, r_opa, r_opb, r_result, r_mdr;
    mcd_pkg::t_word n_pc, n_instr, n_opa, n_opb, n_result, n_mdr;

    // Register file bookkeeping: valid bits and read bypass
    logic [mcd_pkg::REG_COUNT-1:0] r_reg_vld;
    logic                          r_pend_a, r_pend_b;
    logic                          r_byp_a, r_byp_b;
    mcd_pkg::t_word                r_byp_data_a, r_byp_data_b;

    // Output register
    logic               r_out_valid;
    mcd_pkg::t_out_item r_out;
    mcd_pkg::t_out_item n_out;

    logic           w_adv, w_run, w_clr, w_hold, w_ld_ir;
    logic [5:0]     w_en;
    mcd_pkg::t_word w_ram_q_a, w_ram_q_b;
    mcd_pkg::t_word w_ram_a, w_ram_b, w_a_cur, w_b_cur, w_a_use, w_b_use;
    mcd_pkg::t_word w_res_use, w_mdr_use, w_wdata, w_alu_res;
    logic [AW-1:0]  w_waddr, w_raddr_a, w_raddr_b;
    logic           w_we, w_re_a, w_re_b;
    mcd_pkg::t_alu_in w_alu_in;

    // Handshake: process the held item when the output slot is free
    assign w_adv          = r_in_valid && (!r_out_valid || o_res.ready);
    assign i_ctrl.ready   = !r_in_valid || w_adv;
    assign o_res.valid    = r_out_valid;
    assign o_res.payload  = r_out;

    // Mode decode; unused code 3 behaves as hold
    assign w_run   = (r_in.mode == mcd_pkg::MODE_RUN);
    assign w_clr   = (r_in.mode == mcd_pkg::MODE_CLEAR);
    assign w_hold  = !w_run && !w_clr;
    assign w_en    = r_in.enables;
    assign w_ld_ir = w_en[mcd_pkg::EN_INSTR];

    // Operand values left by the previous word, RAM reads resolved here
    assign w_ram_a = r_byp_a ? r_byp_data_a : w_ram_q_a;
    assign w_ram_b = r_byp_b ? r_byp_data_b : w_ram_q_b;
    assign w_a_cur = r_pend_a ? w_ram_a : r_opa;
    assign w_b_cur = r_pend_b ? w_ram_b : r_opb;

    // Instruction load clears A, B, result and MDR first
    assign n_instr   = w_ld_ir ? r_in.data_in : r_instr;
    assign w_a_use   = w_ld_ir ? '0 : w_a_cur;
    assign w_b_use   = w_ld_ir ? '0 : w_b_cur;
    assign w_res_use = w_ld_ir ? '0 : r_result;
    assign w_mdr_use = w_ld_ir ? '0 : r_mdr;

    // Register file write, then operand read addresses
    assign w_wdata   = r_in.din_sel ? w_mdr_use : w_res_use;
    assign w_waddr   = r_in.dest_sel ? mcd_pkg::LINK_REG : n_instr[11:8];
    assign w_we      = w_adv && w_run && r_in.rf_we;
    assign w_raddr_a = n_instr[7:4];
    assign w_raddr_b = n_instr[3:0];
    assign w_re_a    = w_adv && w_run && w_en[mcd_pkg::EN_A];
    assign w_re_b    = w_adv && w_run && w_en[mcd_pkg::EN_B];

    mcd_ram #(
        .DATA_W (mcd_pkg::WORD_BITS),
        .DEPTH  (mcd_pkg::REG_COUNT)
    ) u_regfile (
        .i_clk     (i_clk),
        .i_we      (w_we),
        .i_waddr   (w_waddr),
        .i_wdata   (w_wdata),
        .i_re_a    (w_re_a),
        .i_raddr_a (w_raddr_a),
        .o_rdata_a (w_ram_q_a),
        .i_re_b    (w_re_b),
        .i_raddr_b (w_raddr_b),
        .o_rdata_b (w_ram_q_b)
    );

    // ALU on the operands from before this word's read
    assign w_alu_in.op = r_in.alu_op;
    assign w_alu_in.a  = w_a_use;
    assign w_alu_in.b  = w_b_use;
    assign w_alu_in.pc = r_pc;
    assign w_alu_in.ir = n_instr;

    mcd_alu u_alu (
        .i_alu (w_alu_in),
        .o_res (w_alu_res)
    );

    // Next state and outputs for a run word
    always_comb begin
        n_result = w_en[mcd_pkg::EN_RESULT] ? w_alu_res : '0;
        n_pc     = w_en[mcd_pkg::EN_PC] ? w_alu_res : r_pc;
        n_mdr    = w_en[mcd_pkg::EN_MDR] ? r_in.data_in : w_mdr_use;
        n_opa    = w_a_use;
        n_opb    = w_b_use;
        n_out.opcode    = w_ld_ir ? r_in.data_in[15:12] : r_out.opcode;
        n_out.st_data   = w_a_use;
        n_out.mem_addr  = r_in.addr_sel ? r_result : n_pc;
        n_out.zero_flag = (w_b_use == '0);
        n_out.neg_flag  = w_b_use[mcd_pkg::WORD_BITS-1];
    end

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_ctrl.valid && i_ctrl.ready) begin
            r_in_valid <= 1'b1;
        end else if (w_adv) begin
            r_in_valid <= 1'b0;
        end
        if (i_ctrl.valid && i_ctrl.ready) begin
            r_in <= i_ctrl.payload;
        end
    end

    // Output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_adv) begin
            r_out_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // Datapath state, register file valid bits and held outputs
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (w_adv && w_clr)) begin
            r_pc      <= '0;
            r_instr   <= '0;
            r_opa     <= '0;
            r_opb     <= '0;
            r_result  <= '0;
            r_mdr     <= '0;
            r_reg_vld <= '0;
            r_pend_a  <= 1'b0;
            r_pend_b  <= 1'b0;
            r_out     <= '{opcode: '0, st_data: '0, mem_addr: '0,
                           zero_flag: 1'b1, neg_flag: 1'b0};
        end else if (w_adv && w_run) begin
            r_pc     <= n_pc;
            r_instr  <= n_instr;
            r_opa    <= n_opa;
            r_opb    <= n_opb;
            r_result <= n_result;
            r_mdr    <= n_mdr;
            r_pend_a <= w_en[mcd_pkg::EN_A];
            r_pend_b <= w_en[mcd_pkg::EN_B];
            r_out    <= n_out;
            if (w_we) begin
                r_reg_vld[w_waddr] <= 1'b1;
            end
        end
    end

    // Bypass for reads of a never-written entry or of the entry written this cycle
    always_ff @(posedge i_clk) begin
        if (w_re_a) begin
            r_byp_a      <= (w_we && (w_waddr == w_raddr_a)) || !r_reg_vld[w_raddr_a];
            r_byp_data_a <= (w_we && (w_waddr == w_raddr_a)) ? w_wdata : '0;
        end
        if (w_re_b) begin
            r_byp_b      <= (w_we && (w_waddr == w_raddr_b)) || !r_reg_vld[w_raddr_b];
            r_byp_data_b <= (w_we && (w_waddr == w_raddr_b)) ? w_wdata : '0;
        end
    end

    // Checks
    `MCD_ASSERT_NXT(a_adv_fills_out, w_adv, o_res.valid)
    `MCD_ASSERT_NXT(a_clear_state, w_adv && w_clr, o_res.payload.zero_flag && (r_reg_vld == '0))
    `MCD_ASSERT_NXT(a_hold_state, w_adv && w_hold, $stable(r_pc) && $stable(r_reg_vld))
    `MCD_ASSERT_IMP(a_ready_when_free, !r_out_valid, i_ctrl.ready)

endmodule

[tb/testbench.sv]
// Self-checking testbench for the multicycle CPU datapath.
`timescale 1ns / 1ps

module testbench;

    // Codes with no name in the package
    localparam logic [1:0] MODE_SPARE  = 2'd3;
    localparam logic [3:0] ALU_ZERO_LO = 4'd14;
    localparam logic [3:0] ALU_ZERO_HI = 4'd15;

    // Load enable masks
    localparam logic [5:0] LD_INSTR  = 6'd1 << mcd_pkg::EN_INSTR;
    localparam logic [5:0] LD_A      = 6'd1 << mcd_pkg::EN_A;
    localparam logic [5:0] LD_B      = 6'd1 << mcd_pkg::EN_B;
    localparam logic [5:0] LD_PC     = 6'd1 << mcd_pkg::EN_PC;
    localparam logic [5:0] LD_RESULT = 6'd1 << mcd_pkg::EN_RESULT;
    localparam logic [5:0] LD_MDR    = 6'd1 << mcd_pkg::EN_MDR;

    localparam int unsigned WORDS_WANTED     = 1250;
    localparam int unsigned LONG_HOLD_CYCLES = 60;
    localparam int unsigned STUCK_LIMIT      = 1000;
    localparam int unsigned SETTLE_CYCLES    = 10;

    typedef struct {
        mcd_pkg::t_in_item word;
        bit                drain_first;
    } t_queued_word;

    logic i_clk;
    logic i_rst_n;

    mcd_in_if  ctrl_if ();
    mcd_out_if res_if ();

    multicycle_cpu_datapath dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctrl  (ctrl_if),
        .o_res   (res_if)
    );

    // Queues between stimulus, driver and checker
    t_queued_word       ctrl_words_queued[$];
    mcd_pkg::t_out_item outputs_due[$];

    int unsigned words_built = 0;
    int unsigned words_taken;
    int unsigned outputs_checked;
    int unsigned tx_gap, rx_gap;
    int unsigned hold_left, holds_done;
    int unsigned stuck_cycles;
    int unsigned failures = 0;
    int unsigned mismatches = 0;
    int unsigned run_words = 0;
    int unsigned clear_words = 0;
    int unsigned hold_words = 0;
    logic [15:0] ops_seen = '0;

    // Datapath state mirror
    mcd_pkg::t_word     pc_m, ir_m, a_m, b_m, res_m, mdr_m;
    mcd_pkg::t_word     rf_m [mcd_pkg::REG_COUNT];
    mcd_pkg::t_out_item out_m;

    function automatic void clear_datapath_mirror();
        pc_m  = '0;
        ir_m  = '0;
        a_m   = '0;
        b_m   = '0;
        res_m = '0;
        mdr_m = '0;
        foreach (rf_m[i]) rf_m[i] = '0;
        out_m = '0;
        out_m.zero_flag = 1'b1;
    endfunction

    // ALU on the operands latched before this cycle; PC and IR are current
    function automatic mcd_pkg::t_word alu_model(logic [3:0] op, mcd_pkg::t_word a,
                                                 mcd_pkg::t_word b);
        mcd_pkg::t_word r;
        case (op)
            mcd_pkg::ALU_ADD:   r = a + b;
            mcd_pkg::ALU_SUB:   r = a - b;
            mcd_pkg::ALU_AND:   r = a & b;
            mcd_pkg::ALU_OR:    r = a | b;
            mcd_pkg::ALU_NOTA:  r = ~a;
            mcd_pkg::ALU_SHL:   r = a << b[3:0];
            mcd_pkg::ALU_SHR:   r = a >> b[3:0];
            mcd_pkg::ALU_IMM8:  r = {8'h00, ir_m[7:0]};
            mcd_pkg::ALU_BIMLO: r = b + {12'h000, ir_m[7:4]};
            mcd_pkg::ALU_BIMHI: r = b + {12'h000, ir_m[11:8]};
            mcd_pkg::ALU_PCINC: r = pc_m + 16'd1;
            mcd_pkg::ALU_PCREL: r = pc_m + {{8{ir_m[11]}}, ir_m[11:4]};
            mcd_pkg::ALU_JUMP:  r = {pc_m[15:12], ir_m[11:0]};
            mcd_pkg::ALU_PASSA: r = a;
            default:            r = '0;
        endcase
        return r;
    endfunction

    // One control word through the mirror; returns the outputs it leaves
    function automatic mcd_pkg::t_out_item next_datapath_outputs(mcd_pkg::t_in_item w);
        mcd_pkg::t_word prev_res, a, b, res;
        logic [3:0]     dst;
        if (w.mode == mcd_pkg::MODE_CLEAR) begin
            clear_datapath_mirror();
        end else if (w.mode == mcd_pkg::MODE_RUN) begin
            prev_res = res_m;
            // instruction load clears the operand pipeline
            if (w.enables[mcd_pkg::EN_INSTR]) begin
                a_m   = '0;
                b_m   = '0;
                res_m = '0;
                mdr_m = '0;
                ir_m  = w.data_in;
                out_m.opcode = ir_m[15:12];
            end
            // register write lands before the operand reads
            if (w.rf_we) begin
                dst = w.dest_sel ? mcd_pkg::LINK_REG : ir_m[11:8];
                rf_m[dst] = w.din_sel ? mdr_m : res_m;
            end
            a = a_m;
            b = b_m;
            out_m.st_data = a;
            if (w.enables[mcd_pkg::EN_A]) a_m = rf_m[ir_m[7:4]];
            if (w.enables[mcd_pkg::EN_B]) b_m = rf_m[ir_m[3:0]];
            res   = alu_model(w.alu_op, a, b);
            res_m = w.enables[mcd_pkg::EN_RESULT] ? res : '0;
            out_m.neg_flag  = b[mcd_pkg::WORD_BITS-1];
            out_m.zero_flag = (b == '0);
            if (w.enables[mcd_pkg::EN_PC]) pc_m = res;
            out_m.mem_addr = w.addr_sel ? prev_res : pc_m;
            if (w.enables[mcd_pkg::EN_MDR]) mdr_m = w.data_in;
        end
        return out_m;
    endfunction

    function automatic mcd_pkg::t_in_item ctrl_word(logic [1:0] mode, logic [3:0] op,
                                                    mcd_pkg::t_word din, logic [5:0] en,
                                                    logic dsel, logic dinsel,
                                                    logic rw, logic asel);
        mcd_pkg::t_in_item w;
        w.mode     = mode;
        w.alu_op   = op;
        w.data_in  = din;
        w.enables  = en;
        w.dest_sel = dsel;
        w.din_sel  = dinsel;
        w.rf_we    = rw;
        w.addr_sel = asel;
        return w;
    endfunction

    task automatic queue_word(mcd_pkg::t_in_item w, bit drain);
        t_queued_word q;
        q.word        = w;
        q.drain_first = drain;
        ctrl_words_queued.push_back(q);
        words_built++;
    endtask

    // Data words lean toward the edges
    function automatic mcd_pkg::t_word rand_word();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 8)  return 16'h0000;
        if (r < 16) return 16'hFFFF;
        if (r < 20) return 16'h8000;
        if (r < 24) return 16'h7FFF;
        return mcd_pkg::t_word'($urandom);
    endfunction

    function automatic logic [3:0] rand_op();
        return 4'($urandom_range(0, 15));
    endfunction

    function automatic logic rand_bit();
        return 1'($urandom);
    endfunction

    // Mostly short gaps, a few long ones, and quiet stretches with none
    function automatic int unsigned idle_len(int unsigned seq);
        int unsigned r;
        r = $urandom_range(0, 99);
        if ((seq / 64) % 4 == 3) return 0;
        if (r < 60) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(6, 25);
    endfunction

    // Fetch, decode, execute, optional memory step, write-back
    task automatic queue_instruction();
        logic [5:0] extra;
        logic [3:0] exec_op;
        bit         drain;
        drain = (words_built % 500 == 250);
        queue_word(ctrl_word(mcd_pkg::MODE_RUN, mcd_pkg::ALU_PCINC, rand_word(),
                             LD_INSTR | LD_PC | (rand_bit() ? LD_RESULT : 6'd0),
                             rand_bit(), rand_bit(), 1'b0, rand_bit()), drain);
        exec_op = ($urandom_range(0, 1) != 0) ? mcd_pkg::ALU_PCREL : rand_op();
        queue_word(ctrl_word(mcd_pkg::MODE_RUN, exec_op,
                             rand_word(), LD_A | LD_B | (rand_bit() ? LD_RESULT : 6'd0),
                             rand_bit(), rand_bit(), 1'b0, rand_bit()), 1'b0);
        extra = ($urandom_range(0, 4) == 0) ? LD_PC : 6'd0;
        if (rand_bit()) extra = extra | LD_A | LD_B;
        queue_word(ctrl_word(mcd_pkg::MODE_RUN, rand_op(), rand_word(), LD_RESULT | extra,
                             rand_bit(), rand_bit(), 1'b0, rand_bit()), 1'b0);
        if ($urandom_range(0, 2) == 0) begin
            if (rand_bit())
                queue_word(ctrl_word(mcd_pkg::MODE_HOLD, rand_op(), rand_word(),
                                     6'($urandom), rand_bit(), rand_bit(), rand_bit(),
                                     rand_bit()), 1'b0);
            queue_word(ctrl_word(mcd_pkg::MODE_RUN, rand_op(), rand_word(),
                                 LD_MDR | (rand_bit() ? LD_RESULT : 6'd0),
                                 1'b0, 1'b0, 1'b0, 1'b1), 1'b0);
        end
        queue_word(ctrl_word(mcd_pkg::MODE_RUN, rand_op(), rand_word(),
                             6'($urandom) & ~LD_INSTR,
                             ($urandom_range(0, 3) == 0), rand_bit(), 1'b1, rand_bit()),
                   1'b0);
    endtask

    task automatic check_field(string name, logic [15:0] want, logic [15:0] got);
        if (want !== got) begin
            mismatches++;
            failures++;
            if (mismatches <= 10)
                $display("mismatch on %s at output %0d: expected %h, got %h",
                         name, outputs_checked, want, got);
        end
    endtask

    // Clock
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Driver: presents queued control words, predicts on each accept
    always @(posedge i_clk) begin : drive_ctrl
        bit           fire;
        t_queued_word q;
        if (!i_rst_n) begin
            ctrl_if.valid   <= 1'b0;
            ctrl_if.payload <= '0;
            tx_gap          <= 0;
            words_taken     <= 0;
            clear_datapath_mirror();
        end else begin
            fire = ctrl_if.valid && ctrl_if.ready;
            if (fire) begin
                outputs_due.push_back(next_datapath_outputs(ctrl_if.payload));
                words_taken <= words_taken + 1;
                case (ctrl_if.payload.mode)
                    mcd_pkg::MODE_RUN: begin
                        run_words++;
                        ops_seen[ctrl_if.payload.alu_op] = 1'b1;
                    end
                    mcd_pkg::MODE_CLEAR: clear_words++;
                    default:             hold_words++;
                endcase
            end
            if (!ctrl_if.valid || fire) begin
                if (tx_gap > 0) begin
                    tx_gap        <= tx_gap - 1;
                    ctrl_if.valid <= 1'b0;
                end else if (ctrl_words_queued.size() > 0 &&
                             !(ctrl_words_queued[0].drain_first &&
                               (fire || words_taken != outputs_checked))) begin
                    q = ctrl_words_queued.pop_front();
                    ctrl_if.valid   <= 1'b1;
                    ctrl_if.payload <= q.word;
                    tx_gap          <= idle_len(words_taken);
                end else begin
                    ctrl_if.valid <= 1'b0;
                end
            end
        end
    end

    // Long receiver hold-offs so the datapath backs up into its input
    always @(posedge i_clk) begin : long_hold
        if (!i_rst_n) begin
            hold_left  <= 0;
            holds_done <= 0;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
        end else if (holds_done < 2 &&
                     outputs_checked >= ((holds_done == 0) ? 350 : 950)) begin
            hold_left  <= LONG_HOLD_CYCLES;
            holds_done <= holds_done + 1;
        end
    end

    // Monitor: compares each accepted output with the oldest prediction
    always @(posedge i_clk) begin : check_outputs
        mcd_pkg::t_out_item due;
        int unsigned        gap;
        if (!i_rst_n) begin
            res_if.ready    <= 1'b0;
            rx_gap          <= 0;
            outputs_checked <= 0;
        end else begin
            if (res_if.valid && res_if.ready) begin
                outputs_checked <= outputs_checked + 1;
                if (outputs_due.size() == 0) begin
                    failures++;
                    mismatches++;
                    if (mismatches <= 10)
                        $display("output %0d arrived with no prediction waiting: %p",
                                 outputs_checked, res_if.payload);
                end else begin
                    due = outputs_due.pop_front();
                    check_field("opcode", 16'(due.opcode), 16'(res_if.payload.opcode));
                    check_field("st_data", due.st_data, res_if.payload.st_data);
                    check_field("mem_addr", due.mem_addr, res_if.payload.mem_addr);
                    check_field("zero_flag", 16'(due.zero_flag),
                                16'(res_if.payload.zero_flag));
                    check_field("neg_flag", 16'(due.neg_flag),
                                16'(res_if.payload.neg_flag));
                end
            end
            if (rx_gap > 0) begin
                rx_gap       <= rx_gap - 1;
                res_if.ready <= 1'b0;
            end else if (hold_left > 0) begin
                res_if.ready <= 1'b0;
            end else begin
                gap = idle_len(outputs_checked);
                if (gap == 0) begin
                    res_if.ready <= 1'b1;
                end else begin
                    res_if.ready <= 1'b0;
                    rx_gap       <= gap - 1;
                end
            end
        end
    end

    // Watchdog on cycles with no accept on either side
    always @(posedge i_clk) begin : watchdog
        if (!i_rst_n || (ctrl_if.valid && ctrl_if.ready) ||
            (res_if.valid && res_if.ready)) begin
            stuck_cycles <= 0;
        end else if (stuck_cycles >= STUCK_LIMIT) begin
            $display("no progress for %0d cycles", stuck_cycles);
            $display("FAIL multicycle_cpu_datapath");
            $finish;
        end else begin
            stuck_cycles <= stuck_cycles + 1;
        end
    end

    // Stimulus, reset and end of run
    initial begin : stimulus
        int unsigned r;
        logic [1:0]  md;
        int unsigned leftover;
        i_rst_n = 1'b0;

        // directed: seed R15 and R3, then walk every ALU op
        queue_word(ctrl_word(mcd_pkg::MODE_CLEAR, mcd_pkg::ALU_ADD, 16'h0000, 6'd0,
                             1'b0, 1'b0, 1'b0, 1'b0), 1'b0);
        queue_word(ctrl_word(mcd_pkg::MODE_RUN, mcd_pkg::ALU_ADD, 16'hFFFF, LD_MDR,
                             1'b0, 1'b0, 1'b0, 1'b0), 1'b0);
        queue_word(ctrl_word(mcd_pkg::MODE_RUN, mcd_pkg::ALU_ADD, 16'h0000, 6'd0,
                             1'b1, 1'b1, 1'b1, 1'b0), 1'b0);
        queue_word(ctrl_word(mcd_pkg::MODE_RUN, mcd_pkg::ALU_IMM8, 16'h0380,
                             LD_INSTR | LD_RESULT, 1'b0, 1'b0, 1'b0, 1'b0), 1'b0);
        queue_word(ctrl_word(mcd_pkg::MODE_RUN, mcd_pkg::ALU_ADD, 16'h0000, 6'd0,
                             1'b0, 1'b0, 1'b1, 1'b1), 1'b0);
        queue_word(ctrl_word(mcd_pkg::MODE_RUN, mcd_pkg::ALU_ADD, 16'hBCF3,
                             LD_INSTR | LD_A | LD_B, 1'b0, 1'b0, 1'b0, 1'b0), 1'b0);
        for (int op = 0; op < 16; op++)
            queue_word(ctrl_word(mcd_pkg::MODE_RUN, 4'(op), (op[0] ? 16'hFFFF : 16'h0000),
                                 LD_A | LD_B | LD_RESULT | (op[1] ? LD_PC : 6'd0),
                                 op[2], op[3],
                                 (4'(op) == mcd_pkg::ALU_IMM8 || 4'(op) == ALU_ZERO_HI),
                                 op[0]), 1'b0);
        // hold and the spare mode, every control bit high
        queue_word(ctrl_word(mcd_pkg::MODE_HOLD, ALU_ZERO_HI, 16'hFFFF, 6'h3F,
                             1'b1, 1'b1, 1'b1, 1'b1), 1'b0);
        queue_word(ctrl_word(MODE_SPARE, ALU_ZERO_LO, 16'hFFFF, 6'h3F,
                             1'b1, 1'b1, 1'b1, 1'b1), 1'b0);
        // instruction load with a write in the same cycle, then result disabled
        queue_word(ctrl_word(mcd_pkg::MODE_RUN, mcd_pkg::ALU_PASSA, 16'h7A5C, 6'h3F,
                             1'b0, 1'b0, 1'b1, 1'b1), 1'b0);
        queue_word(ctrl_word(mcd_pkg::MODE_RUN, mcd_pkg::ALU_SUB, 16'h8000, 6'd0,
                             1'b0, 1'b1, 1'b1, 1'b0), 1'b0);
        queue_word(ctrl_word(mcd_pkg::MODE_CLEAR, mcd_pkg::ALU_ADD, 16'h0000, 6'd0,
                             1'b0, 1'b0, 1'b0, 1'b0), 1'b1);

        // random: mostly instruction sequences, some noise, rare clears
        while (words_built < WORDS_WANTED) begin
            r = $urandom_range(0, 99);
            if (r < 75) begin
                queue_instruction();
            end else if (r < 97) begin
                r = $urandom_range(0, 9);
                md = (r < 8) ? mcd_pkg::MODE_RUN :
                     ((r < 9) ? mcd_pkg::MODE_HOLD : MODE_SPARE);
                queue_word(ctrl_word(md, rand_op(), rand_word(), 6'($urandom), rand_bit(),
                                     rand_bit(), rand_bit(), rand_bit()), 1'b0);
            end else begin
                queue_word(ctrl_word(mcd_pkg::MODE_CLEAR, rand_op(), rand_word(),
                                     6'($urandom), rand_bit(), rand_bit(), rand_bit(),
                                     rand_bit()), 1'b0);
            end
        end

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (words_taken < words_built || outputs_checked < words_built)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        leftover = outputs_due.size();
        if (leftover != 0)
            $display("%0d predicted outputs never arrived", leftover);
        $display("Ran %0d control words (%0d run, %0d clear, %0d hold), ALU ops seen %b",
                 words_taken, run_words, clear_words, hold_words, ops_seen);
        $display("Compared %0d outputs field by field, %0d mismatches",
                 outputs_checked, mismatches);
        if (failures == 0 && leftover == 0) begin
            $display("PASS multicycle_cpu_datapath");
        end else begin
            $display("FAIL multicycle_cpu_datapath");
        end
        $finish;
    end

endmodule

[sim.f]
+incdir+sv
sv/mcd_pkg.sv
sv/mcd_if.sv
sv/mcd_ram.sv
sv/mcd_alu.sv
sv/multicycle_cpu_datapath.sv
tb/testbench.sv
